### rtl/vtcr_pkg.sv
`timescale 1ns / 1ps

package vtcr_pkg;

	localparam int MAX_MEMBERS_DEF = 64;
	localparam int ID_W            = 32;
	localparam int QTR_W           = 16;
	localparam int TOTAL_W         = 18;
	localparam int PLACE_W         = 7;

	typedef struct packed {
		logic [ID_W-1:0]  member_id;
		logic [QTR_W-1:0] quarter_one;
		logic [QTR_W-1:0] quarter_two;
		logic [QTR_W-1:0] quarter_three;
		logic [QTR_W-1:0] quarter_four;
		logic             last_record;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]    ranked_id;
		logic [TOTAL_W-1:0] visit_total;
		logic [PLACE_W-1:0] place;
		logic               final_result;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic               valid;
		logic [ID_W-1:0]    id;
		logic [TOTAL_W-1:0] total;
	} entry_t;

	typedef struct packed {
		logic   load;
		logic   shift;
		entry_t rec;
	} cell_ctl_t;

	typedef struct packed {
		logic fire;
		logic first;
		logic last;
		logic overflow;
	} emit_ctl_t;

endpackage

### rtl/vtcr_cell.sv
`timescale 1ns / 1ps

module vtcr_cell
	import vtcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      prev_take,
	input  entry_t    prev_entry,
	input  entry_t    next_entry,
	output entry_t    entry,
	output logic      take
);

	logic               valid_q;
	logic [ID_W-1:0]    id_q;
	logic [TOTAL_W-1:0] total_q;
	entry_t             take_entry;

	assign entry      = '{valid: valid_q, id: id_q, total: total_q};
	assign take       = ctl.load & (!valid_q | (ctl.rec.total > total_q));
	assign take_entry = prev_take ? prev_entry : ctl.rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_entry.valid;
		end else if (take) begin
			valid_q <= take_entry.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			id_q    <= next_entry.id;
			total_q <= next_entry.total;
		end else if (take) begin
			id_q    <= take_entry.id;
			total_q <= take_entry.total;
		end
	end

endmodule

### rtl/vtcr_rank.sv
`timescale 1ns / 1ps

module vtcr_rank
	import vtcr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  emit_ctl_t ctl,
	input  entry_t    head,
	output logic      strobe,
	output out_item_t result
);

	logic [PLACE_W-1:0] pos_q;
	logic [PLACE_W-1:0] prev_place_q;
	logic [TOTAL_W-1:0] prev_total_q;
	logic [PLACE_W-1:0] place_c;
	logic               strobe_q;
	out_item_t          result_q;

	assign strobe = strobe_q;
	assign result = result_q;

	always_comb begin
		if (ctl.first) begin
			place_c = PLACE_W'(1);
		end else if (head.total != prev_total_q) begin
			place_c = pos_q;
		end else begin
			place_c = prev_place_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctl.fire;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			pos_q        <= ctl.first ? PLACE_W'(2) : pos_q + PLACE_W'(1);
			prev_total_q <= head.total;
			prev_place_q <= place_c;
			result_q     <= '{ranked_id: head.id, visit_total: head.total, place: place_c,
				final_result: ctl.last, overflow: ctl.overflow};
		end
	end

endmodule

### rtl/visit_total_competition_ranker.sv
`timescale 1ns / 1ps

// Ranks a set of member records by total visits, highest first.
// Input: drive item and raise start; the item is taken at a clock edge where
// start is high and busy is low. Non-last items are taken one per cycle.
// Each record is summed into a register, then dropped into a sorted chain of
// MAX_MEMBERS cells the next cycle. Records arriving with the chain full are
// dropped and the set is flagged as overflowed.
// An item with last_record set closes the set: busy stays high while that
// record is inserted and the stored records are emitted. Results then stream
// from the head of the chain, one per cycle, each shown for one cycle with
// strobe high, the first one once the last item has passed the sum register,
// the chain and the result register. Equal totals come out in load order and
// share a competition place; the final record carries final_result. The
// receiver cannot stall the stream. After the last result the chain, count and
// overflow flag are empty and a new set may begin. Reset empties the chain and
// clears strobe; no clearing pass is needed.
module visit_total_competition_ranker
	import vtcr_pkg::*;
#(
	parameter int MAX_MEMBERS = MAX_MEMBERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      strobe,
	output out_item_t result
);

	localparam int CNT_W = $clog2(MAX_MEMBERS + 1);

	logic               valid_s1;
	logic               last_s1;
	logic [ID_W-1:0]    id_s1;
	logic [TOTAL_W-1:0] total_s1;

	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   rem_q;
	logic               dropped_q;
	logic               emit_q;
	logic               first_q;
	logic               full;
	logic               accept;

	cell_ctl_t          cell_ctl;
	emit_ctl_t          emit_ctl;
	entry_t             cell_entry [MAX_MEMBERS];
	logic               cell_take  [MAX_MEMBERS];

	assign busy   = emit_q | (valid_s1 & last_s1);
	assign accept = start & ~busy;
	assign full   = (count_q == CNT_W'(MAX_MEMBERS));

	assign cell_ctl.load  = valid_s1 & ~full;
	assign cell_ctl.shift = emit_q;
	assign cell_ctl.rec   = '{valid: 1'b1, id: id_s1, total: total_s1};

	assign emit_ctl.fire     = emit_q;
	assign emit_ctl.first    = first_q;
	assign emit_ctl.last     = (rem_q == CNT_W'(1));
	assign emit_ctl.overflow = dropped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_s1    <= item.member_id;
			last_s1  <= item.last_record;
			total_s1 <= TOTAL_W'(item.quarter_one) + TOTAL_W'(item.quarter_two)
				+ TOTAL_W'(item.quarter_three) + TOTAL_W'(item.quarter_four);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
			emit_q    <= 1'b0;
			first_q   <= 1'b0;
			rem_q     <= '0;
		end else if (emit_q) begin
			first_q <= 1'b0;
			rem_q   <= rem_q - CNT_W'(1);
			if (emit_ctl.last) begin
				emit_q    <= 1'b0;
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end else if (valid_s1) begin
			if (full) begin
				dropped_q <= 1'b1;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
			if (last_s1) begin
				emit_q  <= 1'b1;
				first_q <= 1'b1;
				rem_q   <= full ? count_q : count_q + CNT_W'(1);
			end
		end
	end

	for (genvar i = 0; i < MAX_MEMBERS; i++) begin : g_chain
		entry_t prev_entry;
		entry_t next_entry;
		logic   prev_take;

		if (i == 0) begin : g_head
			assign prev_entry = '0;
			assign prev_take  = 1'b0;
		end else begin : g_body
			assign prev_entry = cell_entry[i-1];
			assign prev_take  = cell_take[i-1];
		end

		if (i == MAX_MEMBERS - 1) begin : g_tail
			assign next_entry = '0;
		end else begin : g_link
			assign next_entry = cell_entry[i+1];
		end

		vtcr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl),
			.prev_take  (prev_take),
			.prev_entry (prev_entry),
			.next_entry (next_entry),
			.entry      (cell_entry[i]),
			.take       (cell_take[i])
		);
	end

	vtcr_rank u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (emit_ctl),
		.head   (cell_entry[0]),
		.strobe (strobe),
		.result (result)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_MEMBERS))
		else $error("record count above capacity");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit_q |-> cell_entry[0].valid)
		else $error("emitting from an empty chain");

	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.final_result |=> strobe)
		else $error("result stream broke before final item");

	a_final_frees: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.final_result |-> !busy && !cell_entry[0].valid)
		else $error("chain not drained after final item");

	a_place_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.final_result |=> result.place >= $past(result.place))
		else $error("place decreased within a set");

endmodule
